// ----- sv/tok_pkg.sv -----
`default_nettype none

package tok_pkg;

   // Position counter widths; the result fields show the low 16 bits.
   localparam int LINE_BITS   = 16;
   localparam int COLUMN_BITS = 16;
   localparam int POS_BITS    = 16;

   // Result queue; the depth must be a power of two so that the pointers wrap.
   localparam int FIFO_DEPTH      = 4;
   localparam int FIFO_PTR_BITS   = $clog2(FIFO_DEPTH);
   localparam int FIFO_LEVEL_BITS = $clog2(FIFO_DEPTH + 1);

   // Token classes.
   localparam logic [5:0] CLS_IDENT     = 6'd0;
   localparam logic [5:0] CLS_NUMBER    = 6'd1;
   localparam logic [5:0] CLS_STRING    = 6'd2;
   localparam logic [5:0] CLS_PLUS      = 6'd3;
   localparam logic [5:0] CLS_PLUS_PLUS = 6'd5;
   localparam logic [5:0] CLS_MINUS     = 6'd6;
   localparam logic [5:0] CLS_ARROW     = 6'd8;
   localparam logic [5:0] CLS_STAR      = 6'd9;
   localparam logic [5:0] CLS_STAR_STAR = 6'd11;
   localparam logic [5:0] CLS_SLASH     = 6'd12;
   localparam logic [5:0] CLS_PERCENT   = 6'd14;
   localparam logic [5:0] CLS_ASSIGN    = 6'd16;
   localparam logic [5:0] CLS_BANG      = 6'd18;
   localparam logic [5:0] CLS_LESS      = 6'd20;
   localparam logic [5:0] CLS_GREATER   = 6'd22;
   localparam logic [5:0] CLS_LPAREN    = 6'd24;
   localparam logic [5:0] CLS_RPAREN    = 6'd25;
   localparam logic [5:0] CLS_LBRACE    = 6'd26;
   localparam logic [5:0] CLS_RBRACE    = 6'd27;
   localparam logic [5:0] CLS_LBRACKET  = 6'd28;
   localparam logic [5:0] CLS_RBRACKET  = 6'd29;
   localparam logic [5:0] CLS_COMMA     = 6'd30;
   localparam logic [5:0] CLS_DOT       = 6'd31;
   localparam logic [5:0] CLS_COLON     = 6'd32;
   localparam logic [5:0] CLS_SEMICOLON = 6'd33;
   localparam logic [5:0] CLS_UNKNOWN   = 6'd34;
   localparam logic [5:0] CLS_EOF       = 6'd35;

   // Byte codes.
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_PLUS      = 8'h2B;
   localparam logic [7:0] CH_MINUS     = 8'h2D;
   localparam logic [7:0] CH_STAR      = 8'h2A;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_PERCENT   = 8'h25;
   localparam logic [7:0] CH_EQUAL     = 8'h3D;
   localparam logic [7:0] CH_BANG      = 8'h21;
   localparam logic [7:0] CH_LESS      = 8'h3C;
   localparam logic [7:0] CH_GREATER   = 8'h3E;
   localparam logic [7:0] CH_DOT       = 8'h2E;
   localparam logic [7:0] CH_HIGH      = 8'h80;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_R         = 8'h72;

   // One result beat.
   typedef struct packed {
      logic [5:0]          token_class;
      logic [7:0]          lexeme_byte;
      logic                byte_valid;
      logic                token_end;
      logic [POS_BITS-1:0] line_number;
      logic [POS_BITS-1:0] column_number;
      logic                last_of_run;
   } rsp_type;

   // What the scanner hands to the result queue for one source byte.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    res0;
      rsp_type    res1;
   } scan_out_type;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
   endfunction

   function automatic logic is_word(input logic [7:0] b);
      return is_alpha(b) || is_digit(b) || (b == CH_UNDERSCORE) || (b >= CH_HIGH);
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
   endfunction

   function automatic logic [5:0] single_class(input logic [7:0] p);
      logic [5:0] c;
      case (p)
         CH_PLUS:    c = CLS_PLUS;
         CH_MINUS:   c = CLS_MINUS;
         CH_STAR:    c = CLS_STAR;
         CH_SLASH:   c = CLS_SLASH;
         CH_PERCENT: c = CLS_PERCENT;
         CH_EQUAL:   c = CLS_ASSIGN;
         CH_BANG:    c = CLS_BANG;
         CH_LESS:    c = CLS_LESS;
         CH_GREATER: c = CLS_GREATER;
         default:    c = CLS_UNKNOWN;
      endcase
      return c;
   endfunction

   function automatic logic [5:0] punct_class(input logic [7:0] b);
      logic [5:0] c;
      case (b)
         8'h28:   c = CLS_LPAREN;
         8'h29:   c = CLS_RPAREN;
         8'h7B:   c = CLS_LBRACE;
         8'h7D:   c = CLS_RBRACE;
         8'h5B:   c = CLS_LBRACKET;
         8'h5D:   c = CLS_RBRACKET;
         8'h2C:   c = CLS_COMMA;
         CH_DOT:  c = CLS_DOT;
         8'h3A:   c = CLS_COLON;
         8'h3B:   c = CLS_SEMICOLON;
         default: c = CLS_UNKNOWN;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] unescape(input logic [7:0] b);
      logic [7:0] r;
      case (b)
         CH_N:    r = CH_LF;
         CH_T:    r = CH_TAB;
         CH_R:    r = CH_CR;
         default: r = b;
      endcase
      return r;
   endfunction

   // A result with no position; positions are filled in afterwards.
   function automatic rsp_type make_res(input logic [5:0] cls, input logic [7:0] b,
                                        input logic valid, input logic fin);
      rsp_type r;
      r               = '0;
      r.token_class   = cls;
      r.lexeme_byte   = valid ? b : 8'h00;
      r.byte_valid    = valid;
      r.token_end     = fin;
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- sv/tok_if.sv -----
`default_nettype none

// Source byte channel.
interface tok_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_end;

   modport source (output valid, output data_byte, output is_end, input ready);
   modport sink   (input valid, input data_byte, input is_end, output ready);
endinterface

// Token result channel.
interface tok_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  token_class;
   logic [7:0]  lexeme_byte;
   logic        byte_valid;
   logic        token_end;
   logic [15:0] line_number;
   logic [15:0] column_number;
   logic        last_of_run;

   modport source (output valid, output token_class, output lexeme_byte,
                   output byte_valid, output token_end, output line_number,
                   output column_number, output last_of_run, input ready);
   modport sink   (input valid, input token_class, input lexeme_byte,
                   input byte_valid, input token_end, input line_number,
                   input column_number, input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- sv/tok_scan.sv -----
`default_nettype none

module tok_scan import tok_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         advance,
   input  wire logic [7:0]   data_byte,
   input  wire logic         is_end,
   output scan_out_type      scan_out
);

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUMBER,
      MODE_STRING,
      MODE_ESCAPE,
      MODE_OPER,
      MODE_COMMENT
   } mode_type;

   localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
   localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
   localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
   localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);

   mode_type                 mode_ff, mode_in;
   logic [7:0]               pend_ff, pend_in;
   logic [7:0]               quote_ff, quote_in;
   logic [LINE_BITS-1:0]     line_ff, line_in, line_step;
   logic [COLUMN_BITS-1:0]   col_ff, col_in, col_step;
   logic [1:0]               cnt;
   logic                     start;
   logic                     close_prev;
   logic [5:0]               pair_cls;
   logic                     pair_hit;
   rsp_type                  res [2];

   // Position after this byte; an end marker does not move it.
   always_comb begin
      line_step = line_ff;
      col_step  = col_ff;
      if (!is_end) begin
         if (data_byte == CH_LF) begin
            if (line_ff != LINE_MAX) line_step = line_ff + 1'b1;
            col_step = COL_ONE;
         end else if (col_ff != COL_MAX) begin
            col_step = col_ff + 1'b1;
         end
      end
   end

   // Two-byte operator made of the pending operator and this byte.
   always_comb begin
      pair_hit = 1'b1;
      pair_cls = CLS_UNKNOWN;
      if (data_byte == CH_EQUAL) begin
         pair_cls = single_class(pend_ff) + 6'd1;
      end else if (pend_ff == CH_PLUS && data_byte == CH_PLUS) begin
         pair_cls = CLS_PLUS_PLUS;
      end else if (pend_ff == CH_MINUS && data_byte == CH_GREATER) begin
         pair_cls = CLS_ARROW;
      end else if (pend_ff == CH_STAR && data_byte == CH_STAR) begin
         pair_cls = CLS_STAR_STAR;
      end else begin
         pair_hit = 1'b0;
      end
   end

   // Mode update and the results that this byte causes.
   always_comb begin
      mode_in    = mode_ff;
      pend_in    = pend_ff;
      quote_in   = quote_ff;
      line_in    = line_step;
      col_in     = col_step;
      cnt        = 2'd0;
      start      = 1'b0;
      close_prev = 1'b0;
      res[0]     = '0;
      res[1]     = '0;

      if (is_end) begin
         // Flush whatever token is open, then close the source.
         unique case (mode_ff)
            MODE_IDENT: begin
               res[cnt[0]] = make_res(CLS_IDENT, 8'h00, 1'b0, 1'b1);
               cnt = cnt + 2'd1;
            end
            MODE_NUMBER: begin
               res[cnt[0]] = make_res(CLS_NUMBER, 8'h00, 1'b0, 1'b1);
               cnt = cnt + 2'd1;
            end
            MODE_STRING, MODE_ESCAPE: begin
               res[cnt[0]] = make_res(CLS_STRING, 8'h00, 1'b0, 1'b1);
               cnt = cnt + 2'd1;
            end
            MODE_OPER: begin
               res[cnt[0]] = make_res(single_class(pend_ff), pend_ff, 1'b1, 1'b1);
               cnt = cnt + 2'd1;
            end
            default: begin
            end
         endcase
         res[cnt[0]] = make_res(CLS_EOF, 8'h00, 1'b0, 1'b1);
         cnt      = cnt + 2'd1;
         mode_in  = MODE_IDLE;
         pend_in  = 8'h00;
         quote_in = 8'h00;
         line_in  = LINE_ONE;
         col_in   = COL_ONE;
      end else begin
         unique case (mode_ff)
            MODE_IDENT, MODE_NUMBER: begin
               if ((mode_ff == MODE_IDENT) ? is_word(data_byte)
                     : (is_digit(data_byte) || data_byte == CH_DOT)) begin
                  res[cnt[0]] = make_res((mode_ff == MODE_IDENT) ? CLS_IDENT : CLS_NUMBER,
                                         data_byte, 1'b1, 1'b0);
                  cnt = cnt + 2'd1;
               end else begin
                  res[cnt[0]] = make_res((mode_ff == MODE_IDENT) ? CLS_IDENT : CLS_NUMBER,
                                         8'h00, 1'b0, 1'b1);
                  cnt        = cnt + 2'd1;
                  start      = 1'b1;
                  close_prev = 1'b1;
               end
            end
            MODE_STRING: begin
               if (data_byte == quote_ff) begin
                  res[cnt[0]] = make_res(CLS_STRING, 8'h00, 1'b0, 1'b1);
                  cnt     = cnt + 2'd1;
                  mode_in = MODE_IDLE;
               end else if (data_byte == CH_BACKSLASH) begin
                  mode_in = MODE_ESCAPE;
               end else begin
                  res[cnt[0]] = make_res(CLS_STRING, data_byte, 1'b1, 1'b0);
                  cnt = cnt + 2'd1;
               end
            end
            MODE_ESCAPE: begin
               res[cnt[0]] = make_res(CLS_STRING, unescape(data_byte), 1'b1, 1'b0);
               cnt     = cnt + 2'd1;
               mode_in = MODE_STRING;
            end
            MODE_COMMENT: begin
               if (data_byte == CH_LF) mode_in = MODE_IDLE;
            end
            MODE_OPER: begin
               if (pend_ff == CH_SLASH && data_byte == CH_SLASH) begin
                  mode_in = MODE_COMMENT;
               end else if (pair_hit) begin
                  res[0]  = make_res(pair_cls, pend_ff, 1'b1, 1'b0);
                  res[1]  = make_res(pair_cls, data_byte, 1'b1, 1'b1);
                  cnt     = 2'd2;
                  mode_in = MODE_IDLE;
               end else begin
                  res[cnt[0]] = make_res(single_class(pend_ff), pend_ff, 1'b1, 1'b1);
                  cnt        = cnt + 2'd1;
                  start      = 1'b1;
                  close_prev = 1'b1;
               end
            end
            default: begin
               start = 1'b1;
            end
         endcase

         // A byte seen between tokens opens the next one unless it is white space.
         if (start) begin
            mode_in = MODE_IDLE;
            if (is_space(data_byte)) begin
               mode_in = MODE_IDLE;
            end else if (data_byte == CH_DQUOTE || data_byte == CH_SQUOTE) begin
               mode_in  = MODE_STRING;
               quote_in = data_byte;
            end else if (is_digit(data_byte)) begin
               mode_in = MODE_NUMBER;
               res[cnt[0]] = make_res(CLS_NUMBER, data_byte, 1'b1, 1'b0);
               cnt = cnt + 2'd1;
            end else if (is_word(data_byte)) begin
               mode_in = MODE_IDENT;
               res[cnt[0]] = make_res(CLS_IDENT, data_byte, 1'b1, 1'b0);
               cnt = cnt + 2'd1;
            end else if (single_class(data_byte) != CLS_UNKNOWN) begin
               mode_in = MODE_OPER;
               pend_in = data_byte;
            end else begin
               res[cnt[0]] = make_res(punct_class(data_byte), data_byte, 1'b1, 1'b1);
               cnt = cnt + 2'd1;
            end
         end
      end

      // A token closed by the byte that follows it ends where it stood before
      // that byte; every other closing item sees the position after the byte.
      for (int k = 0; k < 2; k++) begin
         if (res[k].token_end) begin
            if (close_prev && k == 0) begin
               res[k].line_number   = POS_BITS'(line_ff);
               res[k].column_number = POS_BITS'(col_ff);
            end else begin
               res[k].line_number   = POS_BITS'(line_step);
               res[k].column_number = POS_BITS'(col_step);
            end
         end
      end
      if (cnt != 2'd0) res[cnt[1]].last_of_run = 1'b1;
   end

   assign scan_out.count = cnt;
   assign scan_out.res0  = res[0];
   assign scan_out.res1  = res[1];

   // Scanner state advances once per consumed byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pend_ff  <= 8'h00;
         quote_ff <= 8'h00;
         line_ff  <= LINE_ONE;
         col_ff   <= COL_ONE;
      end else if (advance) begin
         mode_ff  <= mode_in;
         pend_ff  <= pend_in;
         quote_ff <= quote_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/tok_fifo.sv -----
`default_nettype none

module tok_fifo import tok_pkg::*; (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [1:0]                  push_count,
   input  wire rsp_type                     push0,
   input  wire rsp_type                     push1,
   input  wire logic                        pop,
   output rsp_type                          head,
   output logic [FIFO_LEVEL_BITS-1:0]       level
);

   rsp_type                      mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0]     wr_ff, wr_in, wr_next;
   logic [FIFO_PTR_BITS-1:0]     rd_ff, rd_in;
   logic [FIFO_LEVEL_BITS-1:0]   level_ff, level_in;

   // Pointer and fill level update; up to two beats enter per cycle.
   always_comb begin
      wr_next  = wr_ff + 1'b1;
      wr_in    = wr_ff + FIFO_PTR_BITS'(push_count);
      rd_in    = pop ? FIFO_PTR_BITS'(rd_ff + 1'b1) : rd_ff;
      level_in = level_ff + FIFO_LEVEL_BITS'(push_count) - FIFO_LEVEL_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         level_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         level_ff <= level_in;
      end
   end

   // Result storage.
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) mem_ff[wr_ff] <= push0;
      if (push_count == 2'd2) mem_ff[wr_next] <= push1;
   end

   assign head  = mem_ff[rd_ff];
   assign level = level_ff;

endmodule

`default_nettype wire

// ----- sv/source_tokenizer_stream.sv -----
// Streaming source tokenizer.
// req_ch carries one source byte per beat (data_byte), or an end marker
// (is_end) that flushes any open token and then gives an end-of-file token.
// rsp_ch carries one token item per beat: a lexeme byte, or a closing item
// with the token class and the line and column after the token's last byte,
// or both. last_of_run marks the final item caused by one source byte.
// A source byte gives zero, one or two items.
// An accepted byte is held in the input register; its items reach rsp_ch
// via the queue. One byte is taken every cycle while the four-entry result
// queue has room for two more items, so the sustained rate is one byte per
// cycle when the receiver takes an item every cycle and bytes give at most
// one item on average; the queue's drain rate sets it otherwise.
// Reset clears the scanner to between tokens at line 1, column 1 and
// empties the input stage and the result queue. When the receiver stalls
// the queue fills and req_ch.ready falls; nothing is dropped.
// After an end marker the scanner is back in its reset state.
`default_nettype none

module source_tokenizer_stream import tok_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   tok_req_if.sink  req_ch,
   tok_rsp_if.source rsp_ch
);

   logic                         in_valid_ff;
   logic [7:0]                   in_byte_ff;
   logic                         in_end_ff;
   logic                         consume;
   logic                         pop;
   logic [1:0]                   push_count;
   logic [FIFO_LEVEL_BITS-1:0]   fifo_level;
   scan_out_type                 scan_out;
   rsp_type                      head;

   // The held byte is scanned once the queue can take two beats.
   assign consume      = in_valid_ff && (fifo_level <= FIFO_LEVEL_BITS'(FIFO_DEPTH - 2));
   assign req_ch.ready = !in_valid_ff || consume;
   assign push_count   = consume ? scan_out.count : 2'd0;
   assign pop          = rsp_ch.valid && rsp_ch.ready;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_byte_ff <= req_ch.data_byte;
         in_end_ff  <= req_ch.is_end;
      end
   end

   tok_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .advance   (consume),
      .data_byte (in_byte_ff),
      .is_end    (in_end_ff),
      .scan_out  (scan_out)
   );

   tok_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push0      (scan_out.res0),
      .push1      (scan_out.res1),
      .pop        (pop),
      .head       (head),
      .level      (fifo_level)
   );

   // Result channel.
   assign rsp_ch.valid         = (fifo_level != '0);
   assign rsp_ch.token_class   = head.token_class;
   assign rsp_ch.lexeme_byte   = head.lexeme_byte;
   assign rsp_ch.byte_valid    = head.byte_valid;
   assign rsp_ch.token_end     = head.token_end;
   assign rsp_ch.line_number   = head.line_number;
   assign rsp_ch.column_number = head.column_number;
   assign rsp_ch.last_of_run   = head.last_of_run;

   // The queue never overfills.
   assert property (@(posedge clock) disable iff (reset)
      fifo_level <= FIFO_LEVEL_BITS'(FIFO_DEPTH))
      else $error("result queue overfilled");

   // A beat taken with nothing entering lowers the fill level by one.
   assert property (@(posedge clock) disable iff (reset)
      (pop && push_count == 2'd0) |=> (fifo_level == $past(fifo_level) - 1'b1))
      else $error("result queue level lost track of a pop");

   // An end marker always finishes with an end-of-file token.
   assert property (@(posedge clock) disable iff (reset)
      (consume && in_end_ff) |->
         ((scan_out.count == 2'd1 && scan_out.res0.token_class == CLS_EOF) ||
          (scan_out.count == 2'd2 && scan_out.res1.token_class == CLS_EOF)))
      else $error("end marker without end-of-file token");

   // Every delivered item carries a byte or closes a token.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.byte_valid || rsp_ch.token_end))
      else $error("empty result item");

endmodule

`default_nettype wire
